// ===== design/edf_pkg.sv =====
package edf_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int NUM_TASKS  = 4;

    typedef logic [TICK_WIDTH-1:0] tick_t;

    // Config register indexes
    localparam logic [2:0] REG_DEADLINE0 = 3'd0;
    localparam logic [2:0] REG_DEADLINE1 = 3'd1;
    localparam logic [2:0] REG_DEADLINE2 = 3'd2;
    localparam logic [2:0] REG_DEADLINE3 = 3'd3;
    localparam logic [2:0] REG_IDLE_LEFT = 3'd4;

    // Beat modes
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Reset values
    localparam logic [7:0]  RST_DEADLINE0 = 8'd2;
    localparam logic [7:0]  RST_DEADLINE1 = 8'd4;
    localparam logic [7:0]  RST_DEADLINE2 = 8'd10;
    localparam logic [7:0]  RST_DEADLINE3 = 8'd6;
    localparam logic [15:0] RST_IDLE_LEFT = 16'd14;

endpackage

// ===== design/edf_task_dispatcher.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | mode, task_index
// out     | output    | out_valid / out_stall | selected_task, completed, pending_mask
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One beat per cycle while in_stall is low; each result is registered and appears in the cycle after its input beat.
// The release/tick update, four-way deadline compare and completion are combinational.
// rst_n (async, active low) restores deadlines, idle value and task state.
// A stalled result holds in the output register; in_stall rises only while it waits.
module edf_task_dispatcher
    import edf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [1:0]  task_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  selected_task,
    output logic        completed,
    output logic [3:0]  pending_mask,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  deadline_reg [NUM_TASKS];
    logic [15:0] idle_reg;

    logic [3:0]  pend_reg,    pend_next;
    tick_t       elapsed_reg [NUM_TASKS];
    tick_t       elapsed_next[NUM_TASKS];
    tick_t       left_reg    [NUM_TASKS];
    tick_t       left_next   [NUM_TASKS];
    logic [1:0]  sel_reg,     sel_next;
    logic        done_next;

    logic        out_valid_reg;
    logic [1:0]  sel_out_reg;
    logic        done_out_reg;
    logic [3:0]  pend_out_reg;

    logic        accept;

    assign in_stall      = out_valid_reg & out_stall;
    assign accept        = in_valid & ~in_stall;
    assign out_valid     = out_valid_reg;
    assign selected_task = sel_out_reg;
    assign completed     = done_out_reg;
    assign pending_mask  = pend_out_reg;

    always_comb
    begin
        logic       found;
        logic [3:0] wins;
        pend_next    = pend_reg;
        elapsed_next = elapsed_reg;
        left_next    = left_reg;
        sel_next     = sel_reg;
        done_next    = 1'b0;
        found        = 1'b0;
        wins         = '0;
        if (mode == MODE_RELEASE)
        begin
            pend_next[task_index] = 1'b1;
        end
        else
        begin
            // only the lowest-numbered pending task advances
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                if (pend_reg[k] && !found)
                begin
                    found           = 1'b1;
                    elapsed_next[k] = elapsed_reg[k] + tick_t'(1);
                    left_next[k]    = tick_t'(deadline_reg[k]) - elapsed_next[k];
                end
            end
            // strict minimum over the other three, task 0 on a tie
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                wins[k] = 1'b1;
                for (int j = 0; j < NUM_TASKS; j++)
                begin
                    if (j != k && !(left_next[k] < left_next[j]))
                        wins[k] = 1'b0;
                end
            end
            sel_next = 2'd0;
            for (int k = NUM_TASKS - 1; k > 0; k--)
            begin
                if (wins[k])
                    sel_next = 2'(k);
            end
            if (pend_reg[sel_next])
            begin
                done_next                = 1'b1;
                pend_next[sel_next]      = 1'b0;
                elapsed_next[sel_next]   = '0;
                left_next[sel_next]      = tick_t'(idle_reg);
                case (sel_next)
                    2'd0:    pend_next[1] = 1'b1;
                    2'd1:    pend_next[2] = 1'b1;
                    2'd3:    pend_next[2] = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg[0] <= RST_DEADLINE0;
            deadline_reg[1] <= RST_DEADLINE1;
            deadline_reg[2] <= RST_DEADLINE2;
            deadline_reg[3] <= RST_DEADLINE3;
            idle_reg        <= RST_IDLE_LEFT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEADLINE0: deadline_reg[0] <= cfg_data[7:0];
                REG_DEADLINE1: deadline_reg[1] <= cfg_data[7:0];
                REG_DEADLINE2: deadline_reg[2] <= cfg_data[7:0];
                REG_DEADLINE3: deadline_reg[3] <= cfg_data[7:0];
                REG_IDLE_LEFT: idle_reg        <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            sel_reg  <= '0;
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                elapsed_reg[k] <= '0;
                left_reg[k]    <= tick_t'(RST_IDLE_LEFT);
            end
        end
        else if (accept)
        begin
            pend_reg    <= pend_next;
            sel_reg     <= sel_next;
            elapsed_reg <= elapsed_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sel_out_reg  <= sel_next;
            done_out_reg <= done_next;
            pend_out_reg <= pend_next;
        end
    end

    // a completed task is no longer pending and its elapsed count restarted
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_out_reg |->
            !pend_out_reg[sel_out_reg] && elapsed_reg[sel_out_reg] == '0)
        else $error("completed task still pending or elapsed not cleared");

    // a release beat never completes and keeps the prior selection
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == MODE_RELEASE |=>
            out_valid_reg && !done_out_reg && pend_out_reg[$past(task_index)]
            && sel_out_reg == $past(sel_reg))
        else $error("release beat result wrong");

    // the result shows the live scheduler state while it waits
    a_mask_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> pend_out_reg == pend_reg && sel_out_reg == sel_reg)
        else $error("result register out of step with state");

endmodule
